// ===== src/fscc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fscc_pkg
// Shared types and constants for the FAT short-name character crunch.
// ----------------------------------------------------------------------------
package fscc_pkg;

	localparam int unsigned CodeW   = 16;
	localparam int unsigned ByteW   = 8;
	localparam int unsigned BudgetW = 8;

	localparam logic [BudgetW-1:0] BudgetReset   = 8'd11;
	localparam logic [ByteW-1:0]   ByteUnderline = 8'h5F;
	localparam logic [ByteW-1:0]   CaseOffset    = 8'h20;
	localparam logic [CodeW-1:0]   CodeDot       = 16'h002E;
	localparam logic [CodeW-1:0]   CodeSpace     = 16'h0020;
	localparam logic [CodeW-1:0]   CodeWideMin   = 16'h0100;

	typedef struct packed {
		logic             term;
		logic             skip;
		logic             special;
		logic [ByteW-1:0] fat_char;
	} char_info_t;

	typedef struct packed {
		logic [CodeW-1:0] code_unit;
		logic             first_of_name;
	} in_req_t;

	typedef struct packed {
		logic               byte_valid;
		logic [ByteW-1:0]   fat_byte;
		logic               special_found;
		logic [BudgetW-1:0] budget_left;
	} out_req_t;

	function automatic logic is_lower(input logic [ByteW:0] c);
		logic r;
		r = (c >= 9'h061 && c <= 9'h07A) || (c >= 9'h0E0 && c <= 9'h0F6) ||
			(c >= 9'h0F8 && c <= 9'h0FE);
		return r;
	endfunction

	function automatic logic is_punct(input logic [ByteW-1:0] c);
		logic r;
		case (c)
			8'h5C, 8'h2E, 8'h5F, 8'h5E, 8'h24, 8'h7E, 8'h21, 8'h23, 8'h25,
			8'h26, 8'h2D, 8'h7B, 8'h7D, 8'h28, 8'h29, 8'h40, 8'h60,
			8'h27:   r = 1'b1;
			default: r = 1'b0;
		endcase
		return r;
	endfunction

endpackage

// ===== src/fscc_char_map.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fscc_char_map
// Classifies one code unit and maps it to its upper-case short-name byte.
// ----------------------------------------------------------------------------
module fscc_char_map
	import fscc_pkg::*;
(
	input  logic [CodeW-1:0] code_unit,
	output char_info_t       info
);

	logic [ByteW-1:0] c8;
	logic [ByteW:0]   c9;
	logic             narrow;
	logic             lower;
	logic             upper;
	logic             digit;
	logic             valid_char;

	assign c8     = code_unit[ByteW-1:0];
	assign c9     = {1'b0, c8};
	assign narrow = (code_unit < CodeWideMin);
	assign lower  = narrow && is_lower(c9);
	assign upper  = narrow && is_lower(c9 + {1'b0, CaseOffset});
	assign digit  = narrow && (c8 >= 8'h30) && (c8 <= 8'h39);
	assign valid_char = lower || upper || digit || (narrow && is_punct(c8));

	always_comb begin
		info.term    = (code_unit == '0);
		info.skip    = (code_unit == CodeDot) || (code_unit == CodeSpace);
		info.special = !valid_char;
		if (!valid_char) begin
			info.fat_char = ByteUnderline;
		end else if (lower) begin
			info.fat_char = c8 - CaseOffset;
		end else begin
			info.fat_char = c8;
		end
	end

endmodule

// ===== src/fscc_name_state.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fscc_name_state
// Per-name budget, sticky flag and end state; produces one result per request.
// ----------------------------------------------------------------------------
module fscc_name_state
	import fscc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  logic               first_of_name,
	input  char_info_t         info,
	input  logic [BudgetW-1:0] name_budget,
	output out_req_t           result
);

	logic [BudgetW-1:0] remaining_q;
	logic               special_q;
	logic               ended_q;

	logic [BudgetW-1:0] rem_base;
	logic               spec_base;
	logic               end_base;
	logic [BudgetW-1:0] rem_next;
	logic               spec_next;
	logic               end_next;
	logic               byte_valid;

	always_comb begin
		rem_base   = first_of_name ? name_budget : remaining_q;
		spec_base  = first_of_name ? 1'b0 : special_q;
		end_base   = first_of_name ? 1'b0 : ended_q;
		rem_next   = rem_base;
		spec_next  = spec_base;
		end_next   = end_base;
		byte_valid = 1'b0;
		if (!end_base && rem_base != '0) begin
			if (info.term) begin
				end_next = 1'b1;
			end else if (!info.skip) begin
				byte_valid = 1'b1;
				spec_next  = spec_base | info.special;
				rem_next   = rem_base - 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			remaining_q <= '0;
			special_q   <= 1'b0;
			ended_q     <= 1'b1;
		end else if (step) begin
			remaining_q <= rem_next;
			special_q   <= spec_next;
			ended_q     <= end_next;
		end
	end

	always_comb begin
		result.byte_valid    = byte_valid;
		result.fat_byte      = byte_valid ? info.fat_char : '0;
		result.special_found = spec_next;
		result.budget_left   = rem_next;
	end

endmodule

// ===== src/fat_short_name_char_crunch_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fat_short_name_char_crunch_core
// Converts a stream of UTF-16 code units into FAT short-name bytes.
//
//   channel | handshake            | payload
//   in      | in_valid / in_ready  | code_unit, first_of_name
//   out     | out_valid / out_ready| byte_valid, fat_byte, special_found,
//           |                      | budget_left
//   cfg     | cfg_wr_en            | cfg_wr_data (name budget)
//
// One request per cycle while out does not stall; a request passes the input
// register, then the result register, and the name state updates as it moves
// into the result register. Reset loads the budget with 11 and opens no name.
// A stall on out holds both registers; in_ready drops only when both are full.
// ----------------------------------------------------------------------------
module fat_short_name_char_crunch_core
	import fscc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [BudgetW-1:0] cfg_wr_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [CodeW-1:0]   code_unit,
	input  logic               first_of_name,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               byte_valid,
	output logic [ByteW-1:0]   fat_byte,
	output logic               special_found,
	output logic [BudgetW-1:0] budget_left
);

	logic [BudgetW-1:0] budget_q;
	logic               valid_s1;
	in_req_t            req_s1;
	logic               valid_s2;
	out_req_t           res_s2;
	logic               advance;
	char_info_t         info;
	out_req_t           result;

	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			budget_q <= BudgetReset;
		end else if (cfg_wr_en) begin
			budget_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			req_s1.code_unit     <= code_unit;
			req_s1.first_of_name <= first_of_name;
		end
	end

	fscc_char_map u_char_map (
		.code_unit (req_s1.code_unit),
		.info      (info)
	);

	fscc_name_state u_name_state (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (advance),
		.first_of_name (req_s1.first_of_name),
		.info          (info),
		.name_budget   (budget_q),
		.result        (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || out_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= result;
		end
	end

	assign out_valid     = valid_s2;
	assign byte_valid    = res_s2.byte_valid;
	assign fat_byte      = res_s2.fat_byte;
	assign special_found = res_s2.special_found;
	assign budget_left   = res_s2.budget_left;

endmodule
